// ===== rtl/core/bse_pkg.sv =====
// Shared types and constants for the early-exit bubble sort block.
package bse_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // One input beat.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_res;
    logic                         overflowed;
  } result_t;

  // Access request from the sequencer to the element memory.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PSTART,
    ST_PHEAD,
    ST_PRUN,
    ST_PTAIL,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/bse_mem.sv =====
// Element store: one write port and one registered read port.
module bse_mem (
  input  logic               clk,
  input  bse_pkg::mem_req_t  req,
  output bse_pkg::data_t     rdata
);

  bse_pkg::data_t mem [bse_pkg::DEPTH];

  // Write and registered read; the sequencer never reads an entry in the cycle it writes it.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/bse_ctrl.sv =====
// Sequencer: loads elements, runs bubble passes through the memory, and emits results.
module bse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bse_pkg::item_t    item,
  output logic              busy,
  output bse_pkg::mem_req_t req,
  input  bse_pkg::data_t    rdata,
  output logic              result_strobe,
  output bse_pkg::result_t  result
);

  bse_pkg::state_t state, state_next;
  bse_pkg::cnt_t   count, count_next;
  bse_pkg::cnt_t   pass, pass_next;
  logic            drop, drop_next;
  logic            swapped, swapped_next;
  bse_pkg::addr_t  k, k_next;
  bse_pkg::data_t  cur, cur_next;
  bse_pkg::addr_t  eidx, eidx_next;
  logic            out_vld, out_vld_next;
  logic            out_final, out_final_next;
  logic            out_ovf, out_ovf_next;
  bse_pkg::cnt_t   limit;

  // Number of entries still unsorted in the current pass.
  assign limit = count - pass;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bse_pkg::ST_LOAD;
      count   <= '0;
      pass    <= '0;
      drop    <= 1'b0;
      swapped <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pass    <= pass_next;
      drop    <= drop_next;
      swapped <= swapped_next;
      out_vld <= out_vld_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    k         <= k_next;
    cur       <= cur_next;
    eidx      <= eidx_next;
    out_final <= out_final_next;
    out_ovf   <= out_ovf_next;
  end

  // Next state and memory requests.
  always_comb begin
    state_next     = state;
    count_next     = count;
    pass_next      = pass;
    drop_next      = drop;
    swapped_next   = swapped;
    k_next         = k;
    cur_next       = cur;
    eidx_next      = eidx;
    out_vld_next   = 1'b0;
    out_final_next = out_final;
    out_ovf_next   = out_ovf;
    req            = '0;
    unique case (state)
      bse_pkg::ST_LOAD: begin
        if (start) begin
          if (count < bse_pkg::cnt_t'(bse_pkg::DEPTH)) begin
            req.we     = 1'b1;
            req.waddr  = count[bse_pkg::ADDR_W-1:0];
            req.wdata  = item.value;
            count_next = count + bse_pkg::cnt_t'(1);
          end else begin
            drop_next = 1'b1;
          end
          if (item.last) begin
            pass_next  = '0;
            state_next = bse_pkg::ST_PSTART;
          end
        end
      end
      bse_pkg::ST_PSTART: begin
        if (limit < bse_pkg::cnt_t'(2)) begin
          eidx_next  = '0;
          state_next = bse_pkg::ST_EMIT;
        end else begin
          req.re       = 1'b1;
          req.raddr    = '0;
          k_next       = bse_pkg::addr_t'(1);
          swapped_next = 1'b0;
          state_next   = bse_pkg::ST_PHEAD;
        end
      end
      bse_pkg::ST_PHEAD: begin
        cur_next   = rdata;
        req.re     = 1'b1;
        req.raddr  = k;
        state_next = bse_pkg::ST_PRUN;
      end
      bse_pkg::ST_PRUN: begin
        // The larger value rides along in cur; the smaller one is written back behind it.
        req.we    = 1'b1;
        req.waddr = k - bse_pkg::addr_t'(1);
        if (cur > rdata) begin
          req.wdata    = rdata;
          swapped_next = 1'b1;
        end else begin
          req.wdata = cur;
          cur_next  = rdata;
        end
        if (bse_pkg::cnt_t'(k) + bse_pkg::cnt_t'(1) < limit) begin
          req.re    = 1'b1;
          req.raddr = k + bse_pkg::addr_t'(1);
          k_next    = k + bse_pkg::addr_t'(1);
        end else begin
          state_next = bse_pkg::ST_PTAIL;
        end
      end
      bse_pkg::ST_PTAIL: begin
        req.we    = 1'b1;
        req.waddr = bse_pkg::addr_t'(limit - bse_pkg::cnt_t'(1));
        req.wdata = cur;
        pass_next = pass + bse_pkg::cnt_t'(1);
        if (swapped && (pass + bse_pkg::cnt_t'(1) < count)) begin
          state_next = bse_pkg::ST_PSTART;
        end else begin
          eidx_next  = '0;
          state_next = bse_pkg::ST_EMIT;
        end
      end
      bse_pkg::ST_EMIT: begin
        // Read one entry a cycle; its beat goes out the cycle after.
        req.re         = 1'b1;
        req.raddr      = eidx;
        out_vld_next   = 1'b1;
        out_ovf_next   = drop;
        out_final_next = (bse_pkg::cnt_t'(eidx) + bse_pkg::cnt_t'(1) == count);
        if (bse_pkg::cnt_t'(eidx) + bse_pkg::cnt_t'(1) == count) begin
          count_next   = '0;
          drop_next    = 1'b0;
          pass_next    = '0;
          swapped_next = 1'b0;
          state_next   = bse_pkg::ST_LOAD;
        end else begin
          eidx_next = eidx + bse_pkg::addr_t'(1);
        end
      end
      default: begin
        state_next = bse_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs.
  assign busy                = (state != bse_pkg::ST_LOAD);
  assign result_strobe       = out_vld;
  assign result.sorted_value = rdata;
  assign result.final_res    = out_final;
  assign result.overflowed   = out_ovf;

`ifndef SYNTHESIS
  // No entry is read in the same cycle that it is written.
  assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re && (req.waddr == req.raddr)))
    else $error("read and write of the same entry in one cycle");

  // The fill count never exceeds the store depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= bse_pkg::cnt_t'(bse_pkg::DEPTH))
    else $error("element count beyond depth");

  // The final beat of a set is followed by a quiet cycle.
  assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_final) |=> !out_vld)
    else $error("beat after the final beat");

  // The compare index stays inside the unsorted region.
  assert property (@(posedge clk) disable iff (rst)
    (state == bse_pkg::ST_PRUN) |-> (bse_pkg::cnt_t'(k) < limit))
    else $error("compare index outside the pass");

  // An emitted beat always comes from an emission read.
  assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ($past(state) == bse_pkg::ST_EMIT))
    else $error("beat without emission read");
`endif

endmodule

// ===== rtl/core/bubble_sort_early_exit_top.sv =====
// Top level of the early-exit bubble sort block.
//
// Channel   Direction  Handshake                    Payload
// input     in         start & !busy accepts a beat item   (value, last)
// result    out        result_strobe, one cycle     result (sorted_value, final_res, overflowed)
//
// A non-last beat is stored, or dropped if the store is full; the block is ready again at once.
// A last beat starts the sort: passes stop after one without a swap, or once nothing is left unsorted.
// Emission then reads one entry a cycle and sends one beat for each stored entry.
// Reset (rst, synchronous) empties the set; the receiver cannot stall the results.
module bubble_sort_early_exit_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bse_pkg::item_t   item,
  output logic             busy,
  output logic             result_strobe,
  output bse_pkg::result_t result
);

  bse_pkg::mem_req_t req;
  bse_pkg::data_t    rdata;

  bse_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .busy          (busy),
    .req           (req),
    .rdata         (rdata),
    .result_strobe (result_strobe),
    .result        (result)
  );

  bse_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule
